/* hdl/srk_pkg.sv */
`timescale 1ns / 1ps
package srk_pkg;

   // Grid and field widths.
   localparam int GRID_SIZE  = 256;
   localparam int ROW_COUNT  = 256;
   localparam int MODE_W     = 8;
   localparam int COEF_W     = 32;
   localparam int KR_W       = 9;
   localparam int UREG_W     = 31;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   // Internal datapath widths: Q31.16 words, sums with guard bits, products.
   localparam int WORD_W = 48;
   localparam int WIDE_W = 50;
   localparam int HALF_W = 24;
   localparam int PROD_W = 96;

   localparam logic signed [WORD_W-1:0] ILIM      = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] ILIM_WIDE = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [WORD_W-1:0] OUT_MAX   = 48'sh0000_7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] OUT_MIN   = -48'sh0000_8000_0000;

   // Reciprocal of six for the divide unit: floor(2^30 / 6).
   localparam int DIV6_SH = 30;
   localparam logic [27:0] DIV6_M = 28'd178956970;

   // Latencies of the arithmetic units and the stage map of the pipeline.
   localparam int FMUL_LAT  = 4;
   localparam int DIV6_LAT  = 5;
   localparam int ST_WAVE   = 1;
   localparam int ST_KSQ    = ST_WAVE + FMUL_LAT;
   localparam int ST_DIFF   = ST_KSQ + 1;
   localparam int ST_EIG    = ST_DIFF + FMUL_LAT;
   localparam int ST_RK     = ST_EIG + 1;
   localparam int RK_PER    = 2 * (FMUL_LAT + 1);
   localparam int ST_K4SUM  = ST_RK + 3 * RK_PER + FMUL_LAT + 1;
   localparam int ST_FIN    = ST_K4SUM + 1;
   localparam int ST_FINM   = ST_FIN + FMUL_LAT;
   localparam int ST_ADD    = ST_FINM + DIV6_LAT;
   localparam int ST_OUT    = ST_ADD + 1;
   localparam int NUM_ST    = ST_OUT + 2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TIME_STEP,
      REG_DIFFUSIVITY,
      REG_VELOCITY_X,
      REG_VELOCITY_Y,
      REG_WAVE_SCALE
   } csr_index_type;

   // Per-item context that travels down the pipeline.
   typedef struct packed {
      logic                     sat;
      logic                     zero;
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [WORD_W-1:0] wa;
      logic signed [WORD_W-1:0] wb;
      logic signed [WORD_W-1:0] sa;
      logic signed [WORD_W-1:0] sb;
      logic signed [WORD_W-1:0] lr;
      logic signed [WORD_W-1:0] li;
   } ctx_type;

   typedef logic signed [KR_W-1:0] kr_table_type [ROW_COUNT];

   // Signed row frequency for every row index, folded past half the grid.
   function automatic kr_table_type build_kr_table();
      kr_table_type t;
      int r;
      for (int i = 0; i < ROW_COUNT; i++) begin
         r = i % GRID_SIZE;
         if (r > GRID_SIZE / 2) begin
            r = r - GRID_SIZE;
         end
         t[i] = KR_W'(r);
      end
      return t;
   endfunction

   localparam kr_table_type KR_TABLE = build_kr_table();

   function automatic logic signed [WIDE_W-1:0] ext50(input logic signed [WORD_W-1:0] x);
      return {{(WIDE_W-WORD_W){x[WORD_W-1]}}, x};
   endfunction

   function automatic logic signed [WORD_W-1:0] sat48(input logic signed [WIDE_W-1:0] x);
      if (x > ILIM_WIDE) begin
         return ILIM;
      end else if (x < -ILIM_WIDE) begin
         return -ILIM;
      end
      return x[WORD_W-1:0];
   endfunction

   function automatic logic hit48(input logic signed [WIDE_W-1:0] x);
      return (x > ILIM_WIDE) || (x < -ILIM_WIDE);
   endfunction

   function automatic logic signed [COEF_W-1:0] clip32(input logic signed [WORD_W-1:0] x);
      if (x > OUT_MAX) begin
         return OUT_MAX[COEF_W-1:0];
      end else if (x < OUT_MIN) begin
         return OUT_MIN[COEF_W-1:0];
      end
      return x[COEF_W-1:0];
   endfunction

   function automatic logic hit32(input logic signed [WORD_W-1:0] x);
      return (x > OUT_MAX) || (x < OUT_MIN);
   endfunction

endpackage

/* hdl/srk_channels.sv */
`timescale 1ns / 1ps
// Request channel: one coefficient with its mode indices.
interface srk_req_if;
   import srk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        row_mode;
   logic [MODE_W-1:0]        col_mode;
   logic signed [COEF_W-1:0] coef_real;
   logic signed [COEF_W-1:0] coef_imag;
   modport source (output valid, row_mode, col_mode, coef_real, coef_imag, input ready);
   modport sink (input valid, row_mode, col_mode, coef_real, coef_imag, output ready);
endinterface

// Response channel: the advanced coefficient and its saturation flag.
interface srk_rsp_if;
   import srk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] next_real;
   logic signed [COEF_W-1:0] next_imag;
   logic                     saturated;
   modport source (output valid, next_real, next_imag, saturated, input ready);
   modport sink (input valid, next_real, next_imag, saturated, output ready);
endinterface

/* hdl/spectral_rk4_mode_update_core.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake             Payload
// req_ch    in   valid/ready           row_mode, col_mode, coef_real, coef_imag
// rsp_ch    out  valid/ready           next_real, next_imag, saturated
// csr       in   csr_wen (no ready)    csr_index, csr_wdata
//
// One request is accepted per cycle while no response is stalled at the output. Its
// response is offered in the last of the 59 pipeline stages. The depth is set by ten
// chained multiply units of four stages, the five-stage divide by six and the add
// stages.
// Reset clears the stage valid bits and the configuration registers.
// While a response waits on rsp_ch.ready the whole pipeline holds, and
// req_ch.ready is low; nothing is lost or repeated.
module spectral_rk4_mode_update_core (
   input  logic                                clock,
   input  logic                                reset,
   srk_req_if.sink                             req_ch,
   srk_rsp_if.source                           rsp_ch,
   input  logic                                csr_wen,
   input  logic [srk_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [srk_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import srk_pkg::*;

   localparam int LAST = NUM_ST - 1;

   logic [UREG_W-1:0]        dt_ff, d_ff, ws_ff;
   logic signed [COEF_W-1:0] vx_ff, vy_ff;
   logic [NUM_ST-1:0]        v_ff, v_in;
   ctx_type                  ctx_ff [NUM_ST];
   ctx_type                  ctx_in [NUM_ST];
   logic                     en;

   logic signed [WORD_W-1:0] dt_w, d_w, vx_w, vy_w;
   logic signed [KR_W+UREG_W:0] kx_prod, ky_prod;

   logic signed [WORD_W-1:0] wz [4];
   logic                     wsat [4];
   logic signed [WORD_W-1:0] bz;
   logic                     bsat;
   logic signed [WORD_W-1:0] dz [4][4];
   logic                     dsat [4][4];
   logic signed [WORD_W-1:0] uz [3][2];
   logic                     usat [3][2];
   logic signed [WORD_W-1:0] ez [2];
   logic                     esat [2];
   logic signed [WORD_W-1:0] qz [2];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= '0;
         d_ff  <= '0;
         ws_ff <= '0;
         vx_ff <= '0;
         vy_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_TIME_STEP:   dt_ff <= csr_wdata[UREG_W-1:0];
            REG_DIFFUSIVITY: d_ff  <= csr_wdata[UREG_W-1:0];
            REG_VELOCITY_X:  vx_ff <= $signed(csr_wdata);
            REG_VELOCITY_Y:  vy_ff <= $signed(csr_wdata);
            REG_WAVE_SCALE:  ws_ff <= csr_wdata[UREG_W-1:0];
            default: ;
         endcase
      end
   end

   assign dt_w = $signed({{(WORD_W-UREG_W){1'b0}}, dt_ff});
   assign d_w  = $signed({{(WORD_W-UREG_W){1'b0}}, d_ff});
   assign vx_w = WORD_W'(vx_ff);
   assign vy_w = WORD_W'(vy_ff);

   // The pipeline moves as one unless a response is stuck at the output.
   assign en            = !v_ff[LAST] || rsp_ch.ready;
   assign req_ch.ready  = en && !reset;
   assign rsp_ch.valid  = v_ff[LAST];
   assign rsp_ch.next_real = ctx_ff[LAST].wa[COEF_W-1:0];
   assign rsp_ch.next_imag = ctx_ff[LAST].wb[COEF_W-1:0];
   assign rsp_ch.saturated = ctx_ff[LAST].sat;

   // Wavenumbers from the folded row frequency and the column index.
   assign kx_prod = $signed(ctx_ff[0].wa[KR_W-1:0]) * $signed({1'b0, ws_ff});
   assign ky_prod = $signed({1'b0, ctx_ff[0].wb[MODE_W-1:0]}) * $signed({1'b0, ws_ff});

   // Squares and advection products of the wavenumbers.
   srk_fmul u_fmul_kxx (.clock(clock), .en(en), .shift17(1'b0),
      .x(ctx_ff[ST_WAVE].wa), .y(ctx_ff[ST_WAVE].wa), .z(wz[0]), .sat(wsat[0]));
   srk_fmul u_fmul_kyy (.clock(clock), .en(en), .shift17(1'b0),
      .x(ctx_ff[ST_WAVE].wb), .y(ctx_ff[ST_WAVE].wb), .z(wz[1]), .sat(wsat[1]));
   srk_fmul u_fmul_kxv (.clock(clock), .en(en), .shift17(1'b0),
      .x(ctx_ff[ST_WAVE].wa), .y(vx_w), .z(wz[2]), .sat(wsat[2]));
   srk_fmul u_fmul_kyv (.clock(clock), .en(en), .shift17(1'b0),
      .x(ctx_ff[ST_WAVE].wb), .y(vy_w), .z(wz[3]), .sat(wsat[3]));

   // Diffusion part of the eigenvalue.
   srk_fmul u_fmul_diff (.clock(clock), .en(en), .shift17(1'b0),
      .x(d_w), .y(ctx_ff[ST_DIFF].lr), .z(bz), .sat(bsat));

   // Four derivative evaluations and three intermediate updates.
   for (genvar j = 0; j < 4; j++) begin : g_deriv
      localparam int DS = ST_RK + j * RK_PER;
      srk_fmul u_fmul_lra (.clock(clock), .en(en), .shift17(1'b0),
         .x(ctx_ff[DS].lr), .y(ctx_ff[DS].wa), .z(dz[j][0]), .sat(dsat[j][0]));
      srk_fmul u_fmul_lib (.clock(clock), .en(en), .shift17(1'b0),
         .x(ctx_ff[DS].li), .y(ctx_ff[DS].wb), .z(dz[j][1]), .sat(dsat[j][1]));
      srk_fmul u_fmul_lia (.clock(clock), .en(en), .shift17(1'b0),
         .x(ctx_ff[DS].li), .y(ctx_ff[DS].wa), .z(dz[j][2]), .sat(dsat[j][2]));
      srk_fmul u_fmul_lrb (.clock(clock), .en(en), .shift17(1'b0),
         .x(ctx_ff[DS].lr), .y(ctx_ff[DS].wb), .z(dz[j][3]), .sat(dsat[j][3]));
   end

   for (genvar j = 0; j < 3; j++) begin : g_update
      localparam int US = ST_RK + j * RK_PER + FMUL_LAT + 1;
      srk_fmul u_fmul_ta (.clock(clock), .en(en), .shift17(j < 2),
         .x(dt_w), .y(ctx_ff[US].wa), .z(uz[j][0]), .sat(usat[j][0]));
      srk_fmul u_fmul_tb (.clock(clock), .en(en), .shift17(j < 2),
         .x(dt_w), .y(ctx_ff[US].wb), .z(uz[j][1]), .sat(usat[j][1]));
   end

   // Final weighted step and the divide by six.
   srk_fmul u_fmul_fa (.clock(clock), .en(en), .shift17(1'b0),
      .x(dt_w), .y(ctx_ff[ST_FIN].sa), .z(ez[0]), .sat(esat[0]));
   srk_fmul u_fmul_fb (.clock(clock), .en(en), .shift17(1'b0),
      .x(dt_w), .y(ctx_ff[ST_FIN].sb), .z(ez[1]), .sat(esat[1]));
   srk_div6 u_div6_a (.clock(clock), .en(en), .x(ez[0]), .q(qz[0]));
   srk_div6 u_div6_b (.clock(clock), .en(en), .x(ez[1]), .q(qz[1]));

   // Next state of every stage: carry the context, then apply the step at its stage.
   always_comb begin
      int k;
      for (int i = 0; i < NUM_ST - 1; i++) begin
         ctx_in[i+1] = ctx_ff[i];
      end
      v_in = {v_ff[NUM_ST-2:0], req_ch.valid && req_ch.ready};

      // Entry: capture the request, fold the row index.
      ctx_in[0]    = '0;
      ctx_in[0].a  = req_ch.coef_real;
      ctx_in[0].b  = req_ch.coef_imag;
      ctx_in[0].wa = WORD_W'(KR_TABLE[req_ch.row_mode]);
      ctx_in[0].wb = $signed({{(WORD_W-MODE_W){1'b0}}, req_ch.col_mode});

      ctx_in[ST_WAVE].wa = WORD_W'(kx_prod);
      ctx_in[ST_WAVE].wb = WORD_W'(ky_prod);

      // Squared wavenumber (held in lr for now) and advection eigenvalue.
      ctx_in[ST_KSQ+1].lr  = sat48(ext50(wz[0]) + ext50(wz[1]));
      ctx_in[ST_KSQ+1].li  = sat48(-(ext50(wz[2]) + ext50(wz[3])));
      ctx_in[ST_KSQ+1].sat = ctx_ff[ST_KSQ].sat | wsat[0] | wsat[1] | wsat[2] | wsat[3]
                           | hit48(ext50(wz[0]) + ext50(wz[1]))
                           | hit48(-(ext50(wz[2]) + ext50(wz[3])));

      // Diffusion eigenvalue, zero-mode test, start the working pair.
      ctx_in[ST_EIG+1].lr   = -bz;
      ctx_in[ST_EIG+1].zero = (ctx_ff[ST_EIG].lr == '0) && (ctx_ff[ST_EIG].li == '0);
      ctx_in[ST_EIG+1].sat  = ctx_ff[ST_EIG].sat | bsat;
      ctx_in[ST_EIG+1].wa   = WORD_W'(ctx_ff[ST_EIG].a);
      ctx_in[ST_EIG+1].wb   = WORD_W'(ctx_ff[ST_EIG].b);

      // Derivative lambda * w.
      for (int j = 0; j < 4; j++) begin
         k = ST_RK + j * RK_PER + FMUL_LAT;
         ctx_in[k+1].wa  = sat48(ext50(dz[j][0]) - ext50(dz[j][1]));
         ctx_in[k+1].wb  = sat48(ext50(dz[j][2]) + ext50(dz[j][3]));
         ctx_in[k+1].sat = ctx_ff[k].sat | dsat[j][0] | dsat[j][1] | dsat[j][2] | dsat[j][3]
                         | hit48(ext50(dz[j][0]) - ext50(dz[j][1]))
                         | hit48(ext50(dz[j][2]) + ext50(dz[j][3]));
      end

      // Intermediate state and running weighted sum of the slopes.
      for (int j = 0; j < 3; j++) begin
         k = ST_RK + j * RK_PER + 2 * FMUL_LAT + 1;
         ctx_in[k+1].wa = sat48(ext50(WORD_W'(ctx_ff[k].a)) + ext50(uz[j][0]));
         ctx_in[k+1].wb = sat48(ext50(WORD_W'(ctx_ff[k].b)) + ext50(uz[j][1]));
         ctx_in[k+1].sat = ctx_ff[k].sat | usat[j][0] | usat[j][1]
                         | hit48(ext50(WORD_W'(ctx_ff[k].a)) + ext50(uz[j][0]))
                         | hit48(ext50(WORD_W'(ctx_ff[k].b)) + ext50(uz[j][1]));
         if (j == 0) begin
            ctx_in[k+1].sa = ctx_ff[k].wa;
            ctx_in[k+1].sb = ctx_ff[k].wb;
         end else begin
            ctx_in[k+1].sa = sat48(ext50(ctx_ff[k].sa) + (ext50(ctx_ff[k].wa) <<< 1));
            ctx_in[k+1].sb = sat48(ext50(ctx_ff[k].sb) + (ext50(ctx_ff[k].wb) <<< 1));
            if (hit48(ext50(ctx_ff[k].sa) + (ext50(ctx_ff[k].wa) <<< 1))
                || hit48(ext50(ctx_ff[k].sb) + (ext50(ctx_ff[k].wb) <<< 1))) begin
               ctx_in[k+1].sat = 1'b1;
            end
         end
      end

      // Add the last slope.
      ctx_in[ST_K4SUM+1].sa  = sat48(ext50(ctx_ff[ST_K4SUM].sa) + ext50(ctx_ff[ST_K4SUM].wa));
      ctx_in[ST_K4SUM+1].sb  = sat48(ext50(ctx_ff[ST_K4SUM].sb) + ext50(ctx_ff[ST_K4SUM].wb));
      ctx_in[ST_K4SUM+1].sat = ctx_ff[ST_K4SUM].sat
                             | hit48(ext50(ctx_ff[ST_K4SUM].sa) + ext50(ctx_ff[ST_K4SUM].wa))
                             | hit48(ext50(ctx_ff[ST_K4SUM].sb) + ext50(ctx_ff[ST_K4SUM].wb));

      ctx_in[ST_FINM+1].sat = ctx_ff[ST_FINM].sat | esat[0] | esat[1];

      // New coefficient in the internal range.
      ctx_in[ST_ADD+1].wa  = sat48(ext50(WORD_W'(ctx_ff[ST_ADD].a)) + ext50(qz[0]));
      ctx_in[ST_ADD+1].wb  = sat48(ext50(WORD_W'(ctx_ff[ST_ADD].b)) + ext50(qz[1]));
      ctx_in[ST_ADD+1].sat = ctx_ff[ST_ADD].sat
                           | hit48(ext50(WORD_W'(ctx_ff[ST_ADD].a)) + ext50(qz[0]))
                           | hit48(ext50(WORD_W'(ctx_ff[ST_ADD].b)) + ext50(qz[1]));

      // Output clipping; the zero mode passes the coefficient through.
      if (ctx_ff[ST_OUT].zero) begin
         ctx_in[ST_OUT+1].wa  = WORD_W'(ctx_ff[ST_OUT].a);
         ctx_in[ST_OUT+1].wb  = WORD_W'(ctx_ff[ST_OUT].b);
         ctx_in[ST_OUT+1].sat = 1'b0;
      end else begin
         ctx_in[ST_OUT+1].wa  = WORD_W'(clip32(ctx_ff[ST_OUT].wa));
         ctx_in[ST_OUT+1].wb  = WORD_W'(clip32(ctx_ff[ST_OUT].wb));
         ctx_in[ST_OUT+1].sat = ctx_ff[ST_OUT].sat | hit32(ctx_ff[ST_OUT].wa)
                              | hit32(ctx_ff[ST_OUT].wb);
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff <= ctx_in;
      end
   end

endmodule

/* hdl/srk_fmul.sv */
`timescale 1ns / 1ps
// Fixed-point multiply: exact product of magnitudes from four partial products,
// rounded half away from zero, shifted by 16 or 17 and saturated. Four stages.
module srk_fmul (
   input  logic                              clock,
   input  logic                              en,
   input  logic                              shift17,
   input  logic signed [srk_pkg::WORD_W-1:0] x,
   input  logic signed [srk_pkg::WORD_W-1:0] y,
   output logic signed [srk_pkg::WORD_W-1:0] z,
   output logic                              sat
);
   import srk_pkg::*;

   logic [WORD_W-1:0]   s1_mx_ff, s1_my_ff;
   logic                s1_neg_ff, s1_sh_ff;
   logic [2*HALF_W-1:0] s2_p00_ff, s2_p01_ff, s2_p10_ff, s2_p11_ff;
   logic                s2_neg_ff, s2_sh_ff;
   logic [PROD_W-1:0]   s3_p_ff;
   logic                s3_neg_ff, s3_sh_ff;
   logic [PROD_W:0]     rnd, rsum, rsh;
   logic [WORD_W-1:0]   mag;
   logic                hit;
   logic signed [WORD_W-1:0] z_in;

   // Rounding, shift and saturation of the full product.
   always_comb begin
      rnd  = s3_sh_ff ? ((PROD_W+1)'(1) << 16) : ((PROD_W+1)'(1) << 15);
      rsum = {1'b0, s3_p_ff} + rnd;
      rsh  = s3_sh_ff ? (rsum >> 17) : (rsum >> 16);
      hit  = rsh > {{(PROD_W+1-WORD_W){1'b0}}, ILIM};
      mag  = rsh[WORD_W-1:0];
      if (hit) begin
         z_in = s3_neg_ff ? -ILIM : ILIM;
      end else begin
         z_in = s3_neg_ff ? -$signed(mag) : $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mx_ff  <= x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
         s1_my_ff  <= y[WORD_W-1] ? WORD_W'(-y) : WORD_W'(y);
         s1_neg_ff <= x[WORD_W-1] ^ y[WORD_W-1];
         s1_sh_ff  <= shift17;
         s2_p00_ff <= s1_mx_ff[HALF_W-1:0] * s1_my_ff[HALF_W-1:0];
         s2_p01_ff <= s1_mx_ff[HALF_W-1:0] * s1_my_ff[WORD_W-1:HALF_W];
         s2_p10_ff <= s1_mx_ff[WORD_W-1:HALF_W] * s1_my_ff[HALF_W-1:0];
         s2_p11_ff <= s1_mx_ff[WORD_W-1:HALF_W] * s1_my_ff[WORD_W-1:HALF_W];
         s2_neg_ff <= s1_neg_ff;
         s2_sh_ff  <= s1_sh_ff;
         s3_p_ff   <= PROD_W'(s2_p00_ff)
                    + (PROD_W'({1'b0, s2_p01_ff} + {1'b0, s2_p10_ff}) << HALF_W)
                    + (PROD_W'(s2_p11_ff) << (2 * HALF_W));
         s3_neg_ff <= s2_neg_ff;
         s3_sh_ff  <= s2_sh_ff;
         z         <= z_in;
         sat       <= hit;
      end
   end

endmodule

/* hdl/srk_div6.sv */
`timescale 1ns / 1ps
// Signed divide by six, rounding half away from zero. The magnitude is split
// into two 24-bit digits, each divided by a reciprocal multiply and one
// correction step. Five stages.
module srk_div6 (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [srk_pkg::WORD_W-1:0] x,
   output logic signed [srk_pkg::WORD_W-1:0] q
);
   import srk_pkg::*;

   logic [WORD_W-1:0] s1_n_ff;
   logic              s1_neg_ff;
   logic [51:0]       s2_ph_ff;
   logic [HALF_W-1:0] s2_nh_ff, s2_nl_ff;
   logic              s2_neg_ff;
   logic [21:0]       s3_qh_ff;
   logic [2:0]        s3_rh_ff;
   logic [HALF_W-1:0] s3_nl_ff;
   logic              s3_neg_ff;
   logic [54:0]       s4_p_ff;
   logic [26:0]       s4_x_ff;
   logic [21:0]       s4_qh_ff;
   logic              s4_neg_ff;

   logic [21:0] qh0;
   logic [24:0] rh0;
   logic [21:0] qh_in;
   logic [2:0]  rh_in;
   logic [24:0] ql0;
   logic [27:0] rl0;
   logic [HALF_W-1:0] ql_in;
   logic [WORD_W-3:0] quo;

   // High digit correction.
   always_comb begin
      qh0 = s2_ph_ff[51:DIV6_SH];
      rh0 = {1'b0, s2_nh_ff} - ((25'(qh0) << 2) + (25'(qh0) << 1));
      if (rh0 >= 25'd6) begin
         qh_in = qh0 + 22'd1;
         rh_in = 3'(rh0 - 25'd6);
      end else begin
         qh_in = qh0;
         rh_in = rh0[2:0];
      end
   end

   // Low digit correction and final sign.
   always_comb begin
      ql0 = s4_p_ff[54:DIV6_SH];
      rl0 = {1'b0, s4_x_ff} - ((28'(ql0) << 2) + (28'(ql0) << 1));
      if (rl0 >= 28'd6) begin
         ql_in = HALF_W'(ql0 + 25'd1);
      end else begin
         ql_in = ql0[HALF_W-1:0];
      end
      quo = {s4_qh_ff, ql_in};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_n_ff   <= (x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x)) + WORD_W'(3);
         s1_neg_ff <= x[WORD_W-1];
         s2_ph_ff  <= s1_n_ff[WORD_W-1:HALF_W] * DIV6_M;
         s2_nh_ff  <= s1_n_ff[WORD_W-1:HALF_W];
         s2_nl_ff  <= s1_n_ff[HALF_W-1:0];
         s2_neg_ff <= s1_neg_ff;
         s3_qh_ff  <= qh_in;
         s3_rh_ff  <= rh_in;
         s3_nl_ff  <= s2_nl_ff;
         s3_neg_ff <= s2_neg_ff;
         s4_p_ff   <= {s3_rh_ff, s3_nl_ff} * DIV6_M;
         s4_x_ff   <= {s3_rh_ff, s3_nl_ff};
         s4_qh_ff  <= s3_qh_ff;
         s4_neg_ff <= s3_neg_ff;
         q         <= s4_neg_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      end
   end

endmodule

/* hdl/srk_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the mode update core.
module srk_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [srk_pkg::COEF_W-1:0]   next_real,
   input logic signed [srk_pkg::COEF_W-1:0]   next_imag,
   input logic                                saturated
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(next_real) && $stable(next_imag)
                                  && $stable(saturated))
      else $error("response payload changed while stalled");

   // The pipeline holds while a response waits, so no request is taken.
   a_stall_blocks_req: assert property (@(posedge clock)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while output stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind spectral_rk4_mode_update_core srk_checker u_srk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .next_real (rsp_ch.next_real),
   .next_imag (rsp_ch.next_imag),
   .saturated (rsp_ch.saturated)
);
